[src/swfw_pkg.sv]
package swfw_pkg;

  // Sine table length and frame buffer address range
  localparam int WAVE_LEN = 255;
  localparam logic [16:0] ADDR_MAX = 17'h1FFFF;

  // Depth of the queue between front and back, in pixels
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_SCALE        = 2'd1,
    REG_CURVE_FACTOR = 2'd2,
    REG_ROW_PITCH    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] phase_step;
    logic [2:0] scale;
    logic [2:0] curve_factor;
    logic [9:0] row_pitch;
  } cfg_t;

  // One pixel's erase and draw, as handed from front to back
  typedef struct packed {
    logic [16:0] erase_address;
    logic        erase_outside;
    logic [16:0] draw_address;
    logic        draw_outside;
    logic [7:0]  color;
  } pair_t;

  typedef enum logic [2:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_INDEX,
    FS_MULT,
    FS_PUSH
  } front_state_t;

  // trunc(sin(i*4pi/255)*6+30)
  localparam logic [5:0] WAVE_ROM [0:WAVE_LEN-1] = '{
    6'd30, 6'd30, 6'd30, 6'd30, 6'd31, 6'd31, 6'd31, 6'd32, 6'd32, 6'd32,
    6'd32, 6'd33, 6'd33, 6'd33, 6'd33,
    6'd34, 6'd34, 6'd34, 6'd34, 6'd34,
    6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35,
    6'd35, 6'd35,
    6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35,
    6'd35, 6'd35,
    6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd33, 6'd33, 6'd33, 6'd33, 6'd33,
    6'd32, 6'd32, 6'd32,
    6'd31, 6'd31, 6'd31, 6'd31, 6'd30, 6'd30, 6'd30,
    6'd29, 6'd29, 6'd29, 6'd29, 6'd28, 6'd28, 6'd28, 6'd27, 6'd27, 6'd27,
    6'd27, 6'd26, 6'd26, 6'd26, 6'd26,
    6'd25, 6'd25, 6'd25, 6'd25, 6'd25,
    6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24,
    6'd24, 6'd24,
    6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24,
    6'd24, 6'd24,
    6'd25, 6'd25, 6'd25, 6'd25, 6'd25, 6'd26, 6'd26, 6'd26, 6'd26, 6'd27,
    6'd27, 6'd27, 6'd27,
    6'd28, 6'd28, 6'd28, 6'd28, 6'd29, 6'd29, 6'd29,
    6'd30, 6'd30, 6'd30, 6'd31, 6'd31, 6'd31, 6'd31, 6'd32, 6'd32, 6'd32,
    6'd32, 6'd33, 6'd33, 6'd33, 6'd33,
    6'd34, 6'd34, 6'd34, 6'd34, 6'd34,
    6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35,
    6'd35, 6'd35,
    6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35,
    6'd35, 6'd35,
    6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd33, 6'd33, 6'd33, 6'd33, 6'd32,
    6'd32, 6'd32, 6'd32,
    6'd31, 6'd31, 6'd31, 6'd30, 6'd30, 6'd30, 6'd30,
    6'd29, 6'd29, 6'd29, 6'd28, 6'd28, 6'd28, 6'd28, 6'd27, 6'd27, 6'd27,
    6'd26, 6'd26, 6'd26, 6'd26, 6'd26,
    6'd25, 6'd25, 6'd25, 6'd25, 6'd25,
    6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24,
    6'd24, 6'd24,
    6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24, 6'd24,
    6'd24, 6'd24,
    6'd25, 6'd25, 6'd25, 6'd25, 6'd25, 6'd26, 6'd26, 6'd26, 6'd26, 6'd27,
    6'd27, 6'd27, 6'd27,
    6'd28, 6'd28, 6'd28, 6'd29, 6'd29, 6'd29
  };

endpackage

[src/sine_wave_flag_warp.sv]
// Sine-wave flag warp. Each accepted source pixel word (column, row, color,
// frame_end) is displaced by two sine-table offsets and turned into two frame
// buffer write words: an erase (data zero) to the address that pixel was last
// drawn at, then a draw (its color, last high) to its new address; outside
// marks a write that must be dropped. The front sequencer steps through index
// and table lookup, row-pitch multiply with the address memory read, then push
// with the memory write; it takes a new pixel only while idle or in the push
// step. The back issues one word per cycle while the output is not stalled,
// two per pixel, behind a two-pixel queue. After reset the address memory is
// cleared, one entry a cycle, through all IMAGE_WIDTH*IMAGE_HEIGHT entries
// (64000 at the defaults); no pixel is accepted during that sweep,
// configuration writes are. Write configuration only while the block is idle.
module sine_wave_flag_warp import swfw_pkg::*; #(
  parameter int IMAGE_WIDTH  = 320,
  parameter int IMAGE_HEIGHT = 200,
  parameter int SCREEN_ROWS  = 200
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [8:0]  column,
  input  logic [7:0]  row,
  input  logic [7:0]  color,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] write_address,
  output logic [7:0]  write_data,
  output logic        outside,
  output logic        last
);

  cfg_t  cfg;
  logic  push_valid, push_ready;
  pair_t push_data;
  logic  pop_valid, pop_ready;
  pair_t pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step   <= 8'd1;
      cfg.scale        <= 3'd2;
      cfg.curve_factor <= 3'd1;
      cfg.row_pitch    <= 10'd320;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PHASE_STEP:   cfg.phase_step   <= cfg_data[7:0];
        REG_SCALE:        cfg.scale        <= cfg_data[2:0];
        REG_CURVE_FACTOR: cfg.curve_factor <= cfg_data[2:0];
        REG_ROW_PITCH:    cfg.row_pitch    <= cfg_data;
        default:          ;
      endcase
    end
  end

  swfw_front #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .SCREEN_ROWS  (SCREEN_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .column     (column),
    .row        (row),
    .color      (color),
    .frame_end  (frame_end),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  swfw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  swfw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_address (write_address),
    .write_data    (write_data),
    .outside       (outside),
    .last          (last)
  );

endmodule

[src/swfw_ram.sv]
module swfw_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/swfw_front.sv]
module swfw_front import swfw_pkg::*; #(
  parameter int IMAGE_WIDTH  = 320,
  parameter int IMAGE_HEIGHT = 200,
  parameter int SCREEN_ROWS  = 200
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic [8:0] column,
  input  logic [7:0] row,
  input  logic [7:0] color,
  input  logic       frame_end,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       push_valid,
  input  logic       push_ready,
  output pair_t      push_data
);

  localparam int PIXEL_COUNT = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int IDX_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  // Reduce a table index sum modulo the wave length
  function automatic logic [7:0] fold255(input logic [12:0] s);
    logic [8:0] f;
    f = 9'(s[12:8]) + 9'(s[7:0]);
    if (f >= 9'(WAVE_LEN)) begin
      f = f - 9'(WAVE_LEN);
    end
    return f[7:0];
  endfunction

  front_state_t state, state_next;

  logic [IDX_W-1:0] clr_addr;
  logic             clr_last;
  logic [7:0]       wave_phase;
  logic [8:0]       phase_sum;
  logic [7:0]       phase_next;

  logic [8:0]       col_q;
  logic [7:0]       row_q;
  logic [7:0]       color_q;
  logic             in_image_q;
  logic [IDX_W-1:0] idx_q;
  logic [12:0]      sum1_q, sum2_q;
  logic [11:0]      xp_q;
  logic [10:0]      yp_q;
  logic [16:0]      addr_q;
  logic [16:0]      old_q;
  logic [16:0]      limit_q;

  logic             accept;
  logic             in_image;
  logic [19:0]      idx_full;
  logic [IDX_W-1:0] idx_next;
  logic [12:0]      sum1_next, sum2_next;
  logic [7:0]       i1, i2;
  logic [11:0]      xp_next;
  logic [10:0]      yp_next;
  logic [20:0]      addr_full;
  logic [16:0]      addr_next;
  logic [19:0]      limit_full;
  logic [16:0]      limit_next;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [16:0]      ram_wdata;
  logic             ram_re;
  logic [16:0]      ram_rdata;

  // Last address drawn for every source pixel
  swfw_ram #(
    .WIDTH (17),
    .DEPTH (PIXEL_COUNT)
  ) u_prev_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_q),
    .rdata (ram_rdata)
  );

  // Classify the incoming word and form the raw table index sums
  always_comb begin
    accept    = in_valid && in_ready;
    in_image  = (11'(column) < 11'(IMAGE_WIDTH)) && (11'(row) < 11'(IMAGE_HEIGHT));
    idx_full  = 20'(row) * 20'(IMAGE_WIDTH) + 20'(column);
    idx_next  = in_image ? idx_full[IDX_W-1:0] : '0;
    sum1_next = 13'(wave_phase) + 13'(cfg.curve_factor) * (13'(column) + 13'(row));
    sum2_next = 13'(wave_phase) + (13'(column) << 2)
              + (13'(cfg.curve_factor) + 13'd1) * 13'(row);
    phase_sum  = 9'(wave_phase) + 9'(cfg.phase_step);
    phase_next = (phase_sum >= 9'(WAVE_LEN)) ? 8'(phase_sum - 9'(WAVE_LEN)) : phase_sum[7:0];
    clr_last   = (clr_addr == IDX_W'(PIXEL_COUNT - 1));
  end

  // Look up the sine offsets and form screen coordinates
  always_comb begin
    i1      = fold255(sum1_q);
    i2      = fold255(sum2_q);
    xp_next = 12'(cfg.scale) * 12'(col_q) + 12'(WAVE_ROM[i1]);
    yp_next = 11'(cfg.scale) * 11'(row_q) + 11'(WAVE_ROM[i2]);
  end

  // Linear address with saturation, and the frame limit
  always_comb begin
    addr_full  = 21'(yp_q) * 21'(cfg.row_pitch) + 21'(xp_q);
    addr_next  = (addr_full > 21'(ADDR_MAX)) ? ADDR_MAX : addr_full[16:0];
    limit_full = 20'(SCREEN_ROWS) * 20'(cfg.row_pitch);
    limit_next = (limit_full > 20'(ADDR_MAX)) ? ADDR_MAX : limit_full[16:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      FS_CLEAR: if (clr_last) state_next = FS_IDLE;
      FS_IDLE:  if (accept) state_next = FS_INDEX;
      FS_INDEX: state_next = FS_MULT;
      FS_MULT:  state_next = FS_PUSH;
      FS_PUSH: begin
        if (push_ready) begin
          state_next = accept ? FS_INDEX : FS_IDLE;
        end
      end
      default:  state_next = FS_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready   = 1'b0;
    push_valid = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = addr_q;
    case (state)
      FS_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      FS_IDLE:  in_ready = 1'b1;
      FS_INDEX: ram_re = 1'b1;
      FS_MULT:  ;
      FS_PUSH: begin
        push_valid = 1'b1;
        in_ready   = push_ready;
        ram_we     = push_ready && in_image_q;
      end
      default:  ;
    endcase
  end

  // Judge both writes against the current frame limit
  always_comb begin
    push_data.erase_address = old_q;
    push_data.erase_outside = !in_image_q || (old_q >= limit_q);
    push_data.draw_address  = addr_q;
    push_data.draw_outside  = addr_q >= limit_q;
    push_data.color         = color_q;
  end

  // Control: state, clearing sweep, wave phase
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FS_CLEAR;
      clr_addr   <= '0;
      wave_phase <= '0;
    end else begin
      state <= state_next;
      if (state == FS_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if (accept && frame_end) begin
        wave_phase <= phase_next;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    limit_q <= limit_next;
    if (accept) begin
      col_q      <= column;
      row_q      <= row;
      color_q    <= color;
      in_image_q <= in_image;
      idx_q      <= idx_next;
      sum1_q     <= sum1_next;
      sum2_q     <= sum2_next;
    end
    if (state == FS_INDEX) begin
      xp_q <= xp_next;
      yp_q <= yp_next;
    end
    if (state == FS_MULT) begin
      addr_q <= addr_next;
      old_q  <= in_image_q ? ram_rdata : '0;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == FS_INDEX)
    else $error("accepted word did not start the index step");

  a_sequence: assert property (@(posedge clk) disable iff (rst)
    state == FS_INDEX |=> state == FS_MULT ##1 state == FS_PUSH)
    else $error("front steps out of order");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    int'(wave_phase) < WAVE_LEN)
    else $error("wave phase out of range");
`endif

endmodule

[src/swfw_queue.sv]
module swfw_queue import swfw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  pair_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output pair_t pop_data
);

  pair_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push, pop;

  always_comb begin
    push_ready = count != QUEUE_CNT_W'(QUEUE_DEPTH);
    pop_valid  = count != '0;
    pop_data   = entries[rd_ptr];
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

  // Hold the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + QUEUE_CNT_W'(1))
    else $error("queue count lost a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - QUEUE_CNT_W'(1))
    else $error("queue count lost a pop");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= QUEUE_DEPTH)
    else $error("queue overfilled");
`endif

endmodule

[src/swfw_back.sv]
module swfw_back import swfw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  pair_t       pop_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] write_address,
  output logic [7:0]  write_data,
  output logic        outside,
  output logic        last
);

  // sel low: erase next, sel high: draw next
  logic sel;
  logic load;

  always_comb begin
    load      = pop_valid && (!out_valid || out_ready);
    pop_ready = load && sel;
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel       <= !sel;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load erase, then draw, from the queue head
  always_ff @(posedge clk) begin
    if (load) begin
      if (sel) begin
        write_address <= pop_data.draw_address;
        write_data    <= pop_data.color;
        outside       <= pop_data.draw_outside;
        last          <= 1'b1;
      end else begin
        write_address <= pop_data.erase_address;
        write_data    <= '0;
        outside       <= pop_data.erase_outside;
        last          <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_erase_then_draw: assert property (@(posedge clk) disable iff (rst)
    load && !sel |=> sel && out_valid && !last)
    else $error("erase word not loaded ahead of draw");

  a_draw_pops: assert property (@(posedge clk) disable iff (rst)
    load && sel |=> !sel && out_valid && last)
    else $error("draw word not loaded with its pop");

  a_draw_zero_free: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> write_data == '0)
    else $error("erase word carries data");
`endif

endmodule

[test/sine_wave_flag_warp_test.sv]
`timescale 1ns / 1ps

module sine_wave_flag_warp_test;
  import swfw_pkg::*;

  localparam int IMG_W = 320;
  localparam int IMG_H = 200;
  localparam int SCREEN_H = 200;
  localparam int IMG_PIXELS = IMG_W * IMG_H;
  localparam int TABLE_LEN = 255;
  localparam int unsigned FB_TOP = 131071;
  // Address memory clear after reset covers all IMG_PIXELS entries
  localparam int STALL_LIMIT = 400000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS = 270;
  localparam int MODE_SPAN = 637;
  localparam int POOL_SIZE = 24;
  // Sine table as runs of equal entries; value climbs 30..35, falls to 24, and so on
  localparam int WAVE_RUNS [44] = '{
    4, 3, 4, 4, 5, 24, 5, 5, 3, 4, 3, 4, 3, 4, 4, 5, 24, 5, 4, 4, 4, 3,
    3, 4, 4, 4, 5, 24, 5, 4, 4, 3, 4, 3, 4, 3, 5, 5, 24, 5, 4, 4, 3, 3
  };

  typedef struct packed {
    logic [16:0] address;
    logic [7:0]  data;
    logic        off_frame;
    logic        is_draw;
  } fb_write_t;

  // Tracks drawn addresses and wave phase, predicts the frame-buffer writes
  class warp_tracker;
    logic [7:0]  phase_step;
    logic [2:0]  scale;
    logic [2:0]  curve;
    logic [9:0]  pitch;
    logic [7:0]  phase;
    logic [16:0] drawn_at [IMG_PIXELS];
    logic [5:0]  wave [TABLE_LEN];
    fb_write_t   pending_writes [$];
    int          mismatches;

    function new();
      int k;
      int v;
      int dir;
      k = 0;
      v = 30;
      dir = 1;
      foreach (WAVE_RUNS[r]) begin
        repeat (WAVE_RUNS[r]) begin
          wave[k] = v[5:0];
          k++;
        end
        if (v == 35) dir = -1;
        if (v == 24) dir = 1;
        v += dir;
      end
      foreach (drawn_at[i]) drawn_at[i] = '0;
      phase = '0;
      phase_step = 8'd1;
      scale = 3'd2;
      curve = 3'd1;
      pitch = 10'd320;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [9:0] value);
      case (idx)
        REG_PHASE_STEP:   phase_step = value[7:0];
        REG_SCALE:        scale = value[2:0];
        REG_CURVE_FACTOR: curve = value[2:0];
        REG_ROW_PITCH:    pitch = value;
        default: ;
      endcase
    endfunction

    // Queue the erase and draw words for one accepted pixel word
    function void take_pixel(logic [8:0] col, logic [7:0] r, logic [7:0] k, logic fe);
      int unsigned limit;
      int unsigned old;
      int unsigned idx;
      int unsigned i1;
      int unsigned i2;
      int unsigned xp;
      int unsigned yp;
      int unsigned addr;
      bit in_image;
      fb_write_t w;
      limit = SCREEN_H * pitch;
      if (limit > FB_TOP) limit = FB_TOP;
      in_image = (col < IMG_W) && (r < IMG_H);
      idx = r * IMG_W + col;
      old = in_image ? drawn_at[idx] : 0;
      w.address = old[16:0];
      w.data = '0;
      w.off_frame = !in_image || old >= limit;
      w.is_draw = 1'b0;
      pending_writes.push_back(w);

      i1 = (phase + curve * (col + r)) % TABLE_LEN;
      i2 = (phase + 4 * col + (curve + 1) * r) % TABLE_LEN;
      xp = scale * col + wave[i1];
      yp = scale * r + wave[i2];
      addr = xp + yp * pitch;
      if (addr > FB_TOP) addr = FB_TOP;
      if (in_image) drawn_at[idx] = addr[16:0];
      w.address = addr[16:0];
      w.data = k;
      w.off_frame = addr >= limit;
      w.is_draw = 1'b1;
      pending_writes.push_back(w);

      if (fe) phase = 8'((phase + phase_step) % TABLE_LEN);
    endfunction

    // Compare one accepted write word against the oldest prediction
    function void check_write(fb_write_t got);
      fb_write_t want;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected write word: address %0d data %0d outside %0b last %0b",
                   got.address, got.data, got.off_frame, got.is_draw);
        return;
      end
      want = pending_writes.pop_front();
      if (got.address !== want.address || got.data !== want.data ||
          got.off_frame !== want.off_frame || got.is_draw !== want.is_draw) begin
        mismatches++;
        if (mismatches <= 10)
          $display("write word mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                   want.address, want.data, want.off_frame, want.is_draw,
                   got.address, got.data, got.off_frame, got.is_draw);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_PHASE_STEP;
  logic [9:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [8:0]  column = '0;
  logic [7:0]  row = '0;
  logic [7:0]  color = '0;
  logic        frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [16:0] write_address;
  logic [7:0]  write_data;
  logic        outside;
  logic        last;

  int send_idle = 6;
  int stall_pct = 68;
  int sent = 0;
  int quiet_cycles = 0;
  warp_tracker tracker = new();

  sine_wave_flag_warp dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the write side at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Note accepted words, mirror register writes, guard against a hang
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (cfg_write) tracker.set_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) tracker.take_pixel(column, row, color, frame_end);
      if (out_valid && out_ready)
        tracker.check_write({write_address, write_data, outside, last});
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Pick the idling mix from how far the stimulus has come
  function automatic void set_idling();
    if (sent < MODE_SPAN) begin
      send_idle = 6;
      stall_pct = 68;
    end else if (sent < 2 * MODE_SPAN) begin
      send_idle = 68;
      stall_pct = 6;
    end else begin
      send_idle = 0;
      stall_pct = 0;
    end
  endfunction

  // Offer one pixel word, after a random gap, and hold it until taken
  task automatic send_pixel(input logic [8:0] c, input logic [7:0] r,
                            input logic [7:0] k, input logic fe);
    set_idling();
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    column <= c;
    row <= r;
    color <= k;
    frame_end <= fe;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Hold off the sender until every predicted word has come out
  task automatic drain();
    in_valid <= 1'b0;
    // Let the monitor note the last accepted word first
    @(posedge clk);
    while (tracker.pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(input logic [7:0] ps, input logic [2:0] sc,
                                input logic [2:0] cf, input logic [9:0] rp);
    cfg_write <= 1'b1;
    cfg_index <= REG_PHASE_STEP;
    cfg_data <= {2'b00, ps};
    @(posedge clk);
    cfg_index <= REG_SCALE;
    cfg_data <= {7'd0, sc};
    @(posedge clk);
    cfg_index <= REG_CURVE_FACTOR;
    cfg_data <= {7'd0, cf};
    @(posedge clk);
    cfg_index <= REG_ROW_PITCH;
    cfg_data <= rp;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [8:0] pool_col [POOL_SIZE];
    logic [7:0] pool_row [POOL_SIZE];
    logic [8:0] c;
    logic [7:0] r;
    int pick;
    int j;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: corners, pixels off the image, redraw of a drawn pixel
    send_pixel(9'd0, 8'd0, 8'h00, 1'b0);
    send_pixel(9'd319, 8'd199, 8'hFF, 1'b0);
    send_pixel(9'd320, 8'd0, 8'h11, 1'b0);
    send_pixel(9'd0, 8'd200, 8'h22, 1'b0);
    send_pixel(9'd511, 8'd255, 8'h80, 1'b0);
    send_pixel(9'h0AA, 8'hAA, 8'h55, 1'b0);
    send_pixel(9'h155, 8'h55, 8'hAA, 1'b0);
    send_pixel(9'd0, 8'd0, 8'h33, 1'b1);
    send_pixel(9'd319, 8'd199, 8'h44, 1'b1);
    send_pixel(9'd0, 8'd0, 8'h66, 1'b0);
    drain();

    // Top settings: address saturation, erase judged against a new limit
    write_settings(8'd254, 3'd4, 3'd7, 10'd1023);
    send_pixel(9'd0, 8'd0, 8'h77, 1'b1);
    send_pixel(9'd319, 8'd199, 8'h88, 1'b0);
    send_pixel(9'd319, 8'd199, 8'h99, 1'b1);
    send_pixel(9'd160, 8'd100, 8'h12, 1'b0);
    drain();

    // Zero scale and zero pitch: every write off the frame
    write_settings(8'd0, 3'd0, 3'd0, 10'd0);
    send_pixel(9'd0, 8'd0, 8'h01, 1'b0);
    send_pixel(9'd319, 8'd199, 8'h02, 1'b1);
    send_pixel(9'd5, 8'd5, 8'h03, 1'b0);
    drain();

    // Revisit a small set of pixels often so stored addresses get erased
    for (j = 0; j < POOL_SIZE; j++) begin
      pool_col[j] = 9'($urandom_range(IMG_W - 1));
      pool_row[j] = 8'($urandom_range(IMG_H - 1));
    end
    pool_col[0] = 9'd0;
    pool_row[0] = 8'd0;
    pool_col[1] = 9'd319;
    pool_row[1] = 8'd199;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: write_settings(8'd0, 3'd1, 3'd0, 10'd1);
        1: write_settings(8'd254, 3'd4, 3'd7, 10'd1023);
        2: write_settings(8'd1, 3'd2, 3'd1, 10'd320);
        default: begin
          write_settings(8'($urandom_range(254)), 3'($urandom_range(4, 1)),
                         3'($urandom_range(7)),
                         ($urandom_range(1) != 0) ? 10'($urandom_range(650, 100))
                                                  : 10'($urandom_range(1023, 1)));
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          j = $urandom_range(POOL_SIZE - 1);
          c = pool_col[j];
          r = pool_row[j];
        end else if (pick < 90) begin
          c = 9'($urandom_range(IMG_W - 1));
          r = 8'($urandom_range(IMG_H - 1));
        end else begin
          c = 9'($urandom);
          r = 8'($urandom);
        end
        send_pixel(c, r, 8'($urandom), $urandom_range(15) == 0);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_writes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/swfw_pkg.sv
src/swfw_ram.sv
src/swfw_front.sv
src/swfw_queue.sv
src/swfw_back.sv
src/sine_wave_flag_warp.sv
test/sine_wave_flag_warp_test.sv
